/* design/ebi_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ebi_pkg
// Shared types, constants and helper functions of the two-axis Euler body
// integrator: payload structs, lane operation codes, step sequencing, saturation.
// ----------------------------------------------------------------------------
package ebi_pkg;

  localparam int DATA_W = 32;
  localparam int FRAC_W = 16;
  // magnitude of a 32 x 32 product after dropping the fraction bits
  localparam int PROD_W = 47;
  // signed width that holds any 32-bit value plus a shifted product
  localparam int SUM_W  = PROD_W + 2;
  localparam int STEP_W = 3;

  localparam logic [1:0] CMD_FORCE  = 2'd0;
  localparam logic [1:0] CMD_TICK   = 2'd1;
  localparam logic [1:0] CMD_SETPOS = 2'd2;

  localparam int ADDR_W = 5;
  localparam logic [2:0] REG_INV_MASS    = 3'd0;
  localparam logic [2:0] REG_FRICTION    = 3'd1;
  localparam logic [2:0] REG_MAX_SPEED_X = 3'd2;
  localparam logic [2:0] REG_MAX_SPEED_Y = 3'd3;
  localparam logic [2:0] REG_ZERO_BAND   = 3'd4;

  localparam logic [31:0] INV_MASS_RST    = 32'd65536;
  localparam logic [31:0] FRICTION_RST    = 32'd65536;
  localparam logic [30:0] MAX_SPEED_X_RST = 31'd19660800;
  localparam logic [30:0] MAX_SPEED_Y_RST = 31'd45875200;
  localparam logic [15:0] ZERO_BAND_RST   = 16'd0;

  typedef struct packed {
    logic [1:0]         command;
    logic signed [31:0] value_x;
    logic signed [31:0] value_y;
    logic [15:0]        delta_time;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] pos_out_x;
    logic signed [31:0] pos_out_y;
    logic signed [31:0] vel_out_x;
    logic signed [31:0] vel_out_y;
  } out_item_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_MUL_DRAG,
    OP_DRAG,
    OP_MUL_ACC,
    OP_ACC,
    OP_MUL_VEL,
    OP_VEL,
    OP_MUL_POS,
    OP_POS,
    OP_MUL_FORCE,
    OP_SETPOS
  } lane_op_t;

  typedef struct packed {
    logic     load;
    lane_op_t op;
  } lane_ctl_t;

  // lane operation for a given command and step
  function automatic lane_op_t step_op(logic [1:0] cmd, logic [STEP_W-1:0] step);
    lane_op_t op;
    op = OP_NONE;
    case (cmd)
      CMD_TICK: begin
        case (step)
          3'd0:    op = OP_MUL_DRAG;
          3'd1:    op = OP_DRAG;
          3'd2:    op = OP_MUL_ACC;
          3'd3:    op = OP_ACC;
          3'd4:    op = OP_MUL_VEL;
          3'd5:    op = OP_VEL;
          3'd6:    op = OP_MUL_POS;
          3'd7:    op = OP_POS;
          default: op = OP_NONE;
        endcase
      end
      CMD_FORCE:  op = (step == '0) ? OP_MUL_FORCE : OP_ACC;
      CMD_SETPOS: op = OP_SETPOS;
      default:    op = OP_NONE;
    endcase
    return op;
  endfunction

  function automatic logic [STEP_W-1:0] last_step(logic [1:0] cmd);
    logic [STEP_W-1:0] s;
    case (cmd)
      CMD_TICK:  s = 3'd7;
      CMD_FORCE: s = 3'd1;
      default:   s = '0;
    endcase
    return s;
  endfunction

  function automatic logic signed [DATA_W-1:0] sat32(logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    hi = $signed({{(SUM_W-DATA_W){1'b0}}, 1'b0, {(DATA_W-1){1'b1}}});
    lo = $signed({{(SUM_W-DATA_W){1'b1}}, 1'b1, {(DATA_W-1){1'b0}}});
    if (v > hi) begin
      return $signed({1'b0, {(DATA_W-1){1'b1}}});
    end else if (v < lo) begin
      return $signed({1'b1, {(DATA_W-1){1'b0}}});
    end
    return $signed(v[DATA_W-1:0]);
  endfunction

endpackage

/* design/ebi_lane.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ebi_lane
// One axis of the body: acceleration, velocity and position state with a
// shared 32 x 32 magnitude multiplier and a post-product add/saturate stage.
// ----------------------------------------------------------------------------
module ebi_lane (
  input  logic                       clk,
  input  logic                       rst_n,
  input  ebi_pkg::lane_ctl_t         ctl,
  input  logic signed [31:0]         value,
  input  logic [15:0]                delta_time,
  input  logic [31:0]                inv_mass,
  input  logic [31:0]                friction,
  input  logic [30:0]                max_speed,
  input  logic [15:0]                zero_band,
  output logic signed [31:0]         pos,
  output logic signed [31:0]         vel
);

  localparam int SW = ebi_pkg::SUM_W;
  localparam int EXT = ebi_pkg::SUM_W - ebi_pkg::DATA_W;

  logic signed [31:0] val_r;
  logic [15:0]        dt_r;
  logic signed [31:0] acc_r, acc_nxt;
  logic signed [31:0] vel_r, vel_nxt;
  logic signed [31:0] pos_r, pos_nxt;
  logic signed [31:0] drag_r, drag_nxt;
  logic [ebi_pkg::PROD_W-1:0] prod_mag_r, prod_mag_nxt;
  logic                       prod_neg_r, prod_neg_nxt;

  logic               mul_en;
  logic signed [31:0] a_op;
  logic [31:0]        b_op;
  logic [31:0]        a_mag;
  logic [63:0]        prod_full;
  logic signed [SW-1:0] prod_s;
  logic signed [SW-1:0] acc_sum, vel_sum, pos_sum;
  logic signed [SW-1:0] lim, vel_clamp, vel_abs;

  always_comb begin
    mul_en = 1'b1;
    a_op   = vel_r;
    b_op   = friction;
    case (ctl.op)
      ebi_pkg::OP_MUL_DRAG: begin
        a_op = vel_r;
        b_op = friction;
      end
      ebi_pkg::OP_MUL_ACC: begin
        a_op = drag_r;
        b_op = inv_mass;
      end
      ebi_pkg::OP_MUL_VEL: begin
        a_op = acc_r;
        b_op = {16'd0, dt_r};
      end
      ebi_pkg::OP_MUL_POS: begin
        a_op = vel_r;
        b_op = {16'd0, dt_r};
      end
      ebi_pkg::OP_MUL_FORCE: begin
        a_op = val_r;
        b_op = inv_mass;
      end
      default: mul_en = 1'b0;
    endcase
  end

  // sign and magnitude so the product truncates toward zero
  assign a_mag        = a_op[31] ? (~a_op + 32'd1) : a_op;
  assign prod_full    = a_mag * b_op;
  assign prod_mag_nxt = prod_full[ebi_pkg::PROD_W+ebi_pkg::FRAC_W-1:ebi_pkg::FRAC_W];
  assign prod_neg_nxt = a_op[31];

  assign prod_s  = prod_neg_r ? -$signed({2'b00, prod_mag_r}) : $signed({2'b00, prod_mag_r});
  assign acc_sum = $signed({{EXT{acc_r[31]}}, acc_r}) + prod_s;
  assign vel_sum = $signed({{EXT{vel_r[31]}}, vel_r}) + prod_s;
  assign pos_sum = $signed({{EXT{pos_r[31]}}, pos_r}) + prod_s;
  assign lim     = $signed({{(SW-31){1'b0}}, max_speed});

  always_comb begin
    if (vel_sum > lim) begin
      vel_clamp = lim;
    end else if (vel_sum < -lim) begin
      vel_clamp = -lim;
    end else begin
      vel_clamp = vel_sum;
    end
    vel_abs = vel_clamp[SW-1] ? -vel_clamp : vel_clamp;
  end

  always_comb begin
    acc_nxt  = acc_r;
    vel_nxt  = vel_r;
    pos_nxt  = pos_r;
    drag_nxt = drag_r;
    case (ctl.op)
      ebi_pkg::OP_DRAG: drag_nxt = ebi_pkg::sat32(-prod_s);
      ebi_pkg::OP_ACC:  acc_nxt  = ebi_pkg::sat32(acc_sum);
      ebi_pkg::OP_VEL: begin
        if (vel_abs <= $signed({{(SW-16){1'b0}}, zero_band})) begin
          vel_nxt = '0;
        end else begin
          vel_nxt = $signed(vel_clamp[31:0]);
        end
      end
      ebi_pkg::OP_POS: begin
        pos_nxt = ebi_pkg::sat32(pos_sum);
        acc_nxt = '0;
      end
      ebi_pkg::OP_SETPOS: pos_nxt = val_r;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r  <= '0;
      vel_r  <= '0;
      pos_r  <= '0;
      drag_r <= '0;
    end else begin
      acc_r  <= acc_nxt;
      vel_r  <= vel_nxt;
      pos_r  <= pos_nxt;
      drag_r <= drag_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      val_r <= value;
      dt_r  <= delta_time;
    end
    if (mul_en) begin
      prod_mag_r <= prod_mag_nxt;
      prod_neg_r <= prod_neg_nxt;
    end
  end

  assign pos = pos_r;
  assign vel = vel_r;

  a_pos_clears_acc: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.op == ebi_pkg::OP_POS |=> acc_r == '0)
    else $error("acceleration not cleared after position update");

  a_vel_in_limit: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.op == ebi_pkg::OP_VEL |=>
      (vel_r <= $signed({1'b0, max_speed}) && vel_r >= -$signed({1'b0, max_speed})))
    else $error("velocity outside speed limit after clamp");

endmodule

/* design/ebi_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ebi_ctrl
// Command sequencer: takes an input transfer, steps both lanes through the
// operations of the command, then hands the result to the output register.
// ----------------------------------------------------------------------------
module ebi_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic [1:0]         in_command,
  input  logic               out_free,
  output logic               in_stall,
  output ebi_pkg::lane_ctl_t ctl,
  output logic               done
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_DONE
  } state_t;

  state_t                         state_r;
  logic [1:0]                     cmd_r;
  logic [ebi_pkg::STEP_W-1:0]     step_r;

  assign in_stall = (state_r != S_IDLE);
  assign done     = (state_r == S_DONE) && out_free;
  assign ctl.load = (state_r == S_IDLE) && in_valid;
  assign ctl.op   = (state_r == S_RUN) ? ebi_pkg::step_op(cmd_r, step_r) : ebi_pkg::OP_NONE;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cmd_r   <= ebi_pkg::CMD_FORCE;
      step_r  <= '0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            cmd_r   <= in_command;
            step_r  <= '0;
            state_r <= S_RUN;
          end
        end
        S_RUN: begin
          if (step_r == ebi_pkg::last_step(cmd_r)) begin
            state_r <= S_DONE;
          end else begin
            step_r <= step_r + 1'b1;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_RUN |-> step_r <= ebi_pkg::last_step(cmd_r))
    else $error("step counter past the end of the command");

  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && !out_free) |=> state_r == S_DONE)
    else $error("finished result dropped while output busy");

endmodule

/* design/euler_body_integrator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// euler_body_integrator
// Two-axis point body in Q16.16: force, Euler tick with drag and speed clamp,
// and position load, one result per command.
//
//   channel  direction  handshake              payload
//   in_      input      in_valid / in_stall    ebi_pkg::in_item_t
//   out_     output     out_valid / out_stall  ebi_pkg::out_item_t
//   cfg_     input      APB psel/penable       32-bit registers at 4*i
//
// tick: four multiply/accumulate pairs per axis through the lane's one multiplier,
//   force: one pair, set position: a single load step
// x and y run in parallel lanes, one item in flight at a time
// a finished result sits in the output register while the next input is taken
// reset (rst_n, synchronous) clears state and loads the register defaults
// ----------------------------------------------------------------------------
module euler_body_integrator (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  ebi_pkg::in_item_t             in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output ebi_pkg::out_item_t            out_data,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [ebi_pkg::ADDR_W-1:0]    cfg_paddr,
  input  logic [31:0]                   cfg_pwdata,
  output logic [31:0]                   cfg_prdata,
  output logic                          cfg_pready
);

  logic [31:0] inv_mass_r;
  logic [31:0] friction_r;
  logic [30:0] max_speed_x_r;
  logic [30:0] max_speed_y_r;
  logic [15:0] zero_band_r;
  logic [2:0]  reg_idx;

  ebi_pkg::lane_ctl_t ctl;
  logic               done;
  logic               out_free;
  logic signed [31:0] pos_x, pos_y, vel_x, vel_y;

  logic               out_valid_r;
  ebi_pkg::out_item_t out_data_r;

  assign cfg_pready = 1'b1;
  assign reg_idx    = cfg_paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_mass_r    <= ebi_pkg::INV_MASS_RST;
      friction_r    <= ebi_pkg::FRICTION_RST;
      max_speed_x_r <= ebi_pkg::MAX_SPEED_X_RST;
      max_speed_y_r <= ebi_pkg::MAX_SPEED_Y_RST;
      zero_band_r   <= ebi_pkg::ZERO_BAND_RST;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
      case (reg_idx)
        ebi_pkg::REG_INV_MASS:    inv_mass_r    <= cfg_pwdata;
        ebi_pkg::REG_FRICTION:    friction_r    <= cfg_pwdata;
        ebi_pkg::REG_MAX_SPEED_X: max_speed_x_r <= cfg_pwdata[30:0];
        ebi_pkg::REG_MAX_SPEED_Y: max_speed_y_r <= cfg_pwdata[30:0];
        ebi_pkg::REG_ZERO_BAND:   zero_band_r   <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      ebi_pkg::REG_INV_MASS:    cfg_prdata = inv_mass_r;
      ebi_pkg::REG_FRICTION:    cfg_prdata = friction_r;
      ebi_pkg::REG_MAX_SPEED_X: cfg_prdata = {1'b0, max_speed_x_r};
      ebi_pkg::REG_MAX_SPEED_Y: cfg_prdata = {1'b0, max_speed_y_r};
      ebi_pkg::REG_ZERO_BAND:   cfg_prdata = {16'd0, zero_band_r};
      default:                  cfg_prdata = '0;
    endcase
  end

  assign out_free = !out_valid_r || !out_stall;

  ebi_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_command (in_data.command),
    .out_free   (out_free),
    .in_stall   (in_stall),
    .ctl        (ctl),
    .done       (done)
  );

  ebi_lane u_lane_x (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .value      (in_data.value_x),
    .delta_time (in_data.delta_time),
    .inv_mass   (inv_mass_r),
    .friction   (friction_r),
    .max_speed  (max_speed_x_r),
    .zero_band  (zero_band_r),
    .pos        (pos_x),
    .vel        (vel_x)
  );

  ebi_lane u_lane_y (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .value      (in_data.value_y),
    .delta_time (in_data.delta_time),
    .inv_mass   (inv_mass_r),
    .friction   (friction_r),
    .max_speed  (max_speed_y_r),
    .zero_band  (zero_band_r),
    .pos        (pos_y),
    .vel        (vel_y)
  );

  // merge both axes into the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (done) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      out_data_r.pos_out_x <= pos_x;
      out_data_r.pos_out_y <= pos_y;
      out_data_r.vel_out_x <= vel_x;
      out_data_r.vel_out_y <= vel_y;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_done_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
    done |=> out_valid_r)
    else $error("finished result not presented on the output");

endmodule

/* tb/tb_euler_body_integrator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_euler_body_integrator
// Self-checking bench for the two-axis Euler body integrator. Commands go in
// over the valid/stall input channel. A local fixed-point body model predicts
// the position and velocity after each accepted command. Every result transfer
// is compared field by field against the oldest prediction. Directed checks
// cover register defaults, saturation, the speed clamp and zero snapping.
// Random phases then run frames of forces and ticks under several register
// settings, the extremes included, with random input gaps and result-side stalls.
// ----------------------------------------------------------------------------
module tb_euler_body_integrator;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int TIMEOUT_NS = 5_000_000;
  localparam int MAX_PRINTED = 50;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  ebi_pkg::in_item_t          in_data = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  ebi_pkg::out_item_t         out_data;
  logic                       cfg_psel = 1'b0;
  logic                       cfg_penable = 1'b0;
  logic                       cfg_pwrite = 1'b0;
  logic [ebi_pkg::ADDR_W-1:0] cfg_paddr = '0;
  logic [31:0]                cfg_pwdata = '0;
  logic [31:0]                cfg_prdata;
  logic                       cfg_pready;

  // body model: register copies and state
  logic [31:0] inv_mass_q    = ebi_pkg::INV_MASS_RST;
  logic [31:0] friction_q    = ebi_pkg::FRICTION_RST;
  logic [30:0] max_speed_x_q = ebi_pkg::MAX_SPEED_X_RST;
  logic [30:0] max_speed_y_q = ebi_pkg::MAX_SPEED_Y_RST;
  logic [15:0] zero_band_q   = ebi_pkg::ZERO_BAND_RST;
  longint acc_x = 0, acc_y = 0, vel_x = 0, vel_y = 0, pos_x = 0, pos_y = 0;

  ebi_pkg::out_item_t pending_motion[$];
  ebi_pkg::out_item_t want_motion;

  int  error_count = 0;
  int  results_seen = 0;
  int  config_writes = 0;
  int  cmd_count[4] = '{0, 0, 0, 0};
  bit  no_idle = 1'b0;
  int  stall_run = 0;
  int  stall_pick;

  euler_body_integrator dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------- model

  function automatic longint clip32(longint v);
    if (v > longint'(32'sh7FFF_FFFF)) return longint'(32'sh7FFF_FFFF);
    if (v < -longint'(33'sh0_8000_0000)) return -longint'(33'sh0_8000_0000);
    return v;
  endfunction

  // signed times unsigned Q16 factor, truncated toward zero
  function automatic longint scale_q16(longint a, longint unsigned b);
    logic [63:0] mag;
    logic [63:0] prod;
    mag = (a < 0) ? 64'(-a) : 64'(a);
    prod = (mag * b) >> ebi_pkg::FRAC_W;
    return (a < 0) ? -longint'(prod) : longint'(prod);
  endfunction

  task automatic tick_lane(inout longint acc, inout longint vel, inout longint pos,
                           input longint lim, input longint unsigned dt);
    longint drag;
    longint v;
    longint mag;
    drag = clip32(-scale_q16(vel, friction_q));
    acc = clip32(acc + scale_q16(drag, inv_mass_q));
    v = vel + scale_q16(acc, dt);
    if (v > lim) v = lim;
    if (v < -lim) v = -lim;
    mag = (v < 0) ? -v : v;
    if (mag <= longint'(zero_band_q)) v = 0;
    vel = v;
    pos = clip32(pos + scale_q16(v, dt));
    acc = 0;
  endtask

  task automatic advance_body(input ebi_pkg::in_item_t it, output ebi_pkg::out_item_t res);
    case (it.command)
      ebi_pkg::CMD_FORCE: begin
        acc_x = clip32(acc_x + scale_q16(longint'(it.value_x), inv_mass_q));
        acc_y = clip32(acc_y + scale_q16(longint'(it.value_y), inv_mass_q));
      end
      ebi_pkg::CMD_TICK: begin
        tick_lane(acc_x, vel_x, pos_x, longint'(max_speed_x_q), it.delta_time);
        tick_lane(acc_y, vel_y, pos_y, longint'(max_speed_y_q), it.delta_time);
      end
      ebi_pkg::CMD_SETPOS: begin
        pos_x = longint'(it.value_x);
        pos_y = longint'(it.value_y);
      end
      default: ;
    endcase
    res.pos_out_x = 32'(pos_x);
    res.pos_out_y = 32'(pos_y);
    res.vel_out_x = 32'(vel_x);
    res.vel_out_y = 32'(vel_y);
  endtask

  // ---------------------------------------------------------------- checking

  task automatic report_error(input string msg);
    error_count++;
    if (error_count <= MAX_PRINTED) $display("ERROR @%0t: %s", $time, msg);
  endtask

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) report_error($sformatf("%s expected %h got %h", name, want, got));
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_motion.size() == 0) begin
        report_error("result transfer with no command outstanding");
      end else begin
        want_motion = pending_motion.pop_front();
        compare_field("pos_out_x", want_motion.pos_out_x, out_data.pos_out_x);
        compare_field("pos_out_y", want_motion.pos_out_y, out_data.pos_out_y);
        compare_field("vel_out_x", want_motion.vel_out_x, out_data.vel_out_x);
        compare_field("vel_out_y", want_motion.vel_out_y, out_data.vel_out_y);
        results_seen++;
      end
    end
  end

  // result side back-pressure: mostly short bursts, now and then a long one
  always @(negedge clk) begin
    if (no_idle) begin
      out_stall = 1'b0;
      stall_run = 0;
    end else if (stall_run > 0) begin
      out_stall = 1'b1;
      stall_run--;
    end else begin
      stall_pick = $urandom_range(0, 99);
      if (stall_pick < 60) begin
        out_stall = 1'b0;
      end else if (stall_pick < 95) begin
        out_stall = 1'b1;
        stall_run = $urandom_range(0, 3);
      end else begin
        out_stall = 1'b1;
        stall_run = $urandom_range(15, 50);
      end
    end
  end

  // ---------------------------------------------------------------- drivers

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_item(input ebi_pkg::in_item_t it);
    int gap;
    ebi_pkg::out_item_t res;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid = 1'b1;
    in_data = it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    advance_body(it, res);
    pending_motion.push_back(res);
    cmd_count[it.command]++;
  endtask

  task automatic send_cmd(input logic [1:0] cmd, input logic [31:0] x, input logic [31:0] y,
                          input logic [15:0] dt);
    ebi_pkg::in_item_t it;
    it.command = cmd;
    it.value_x = x;
    it.value_y = y;
    it.delta_time = dt;
    send_item(it);
  endtask

  // block is idle once the last prediction has been matched
  task automatic wait_idle();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_motion.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic check_register(input logic [2:0] idx, input logic [31:0] want);
    @(negedge clk);
    cfg_psel = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = {idx, 2'b00};
    @(negedge clk);
    cfg_penable = 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    compare_field($sformatf("register %0d readback", idx), want, cfg_prdata);
    @(negedge clk);
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
  endtask

  task automatic set_register(input logic [2:0] idx, input logic [31:0] value);
    logic [31:0] kept;
    @(negedge clk);
    cfg_psel = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b1;
    cfg_paddr = {idx, 2'b00};
    cfg_pwdata = value;
    @(negedge clk);
    cfg_penable = 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    case (idx)
      ebi_pkg::REG_INV_MASS:    inv_mass_q = value;
      ebi_pkg::REG_FRICTION:    friction_q = value;
      ebi_pkg::REG_MAX_SPEED_X: max_speed_x_q = value[30:0];
      ebi_pkg::REG_MAX_SPEED_Y: max_speed_y_q = value[30:0];
      ebi_pkg::REG_ZERO_BAND:   zero_band_q = value[15:0];
      default: ;
    endcase
    config_writes++;
    @(negedge clk);
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    case (idx)
      ebi_pkg::REG_INV_MASS:    kept = inv_mass_q;
      ebi_pkg::REG_FRICTION:    kept = friction_q;
      ebi_pkg::REG_MAX_SPEED_X: kept = {1'b0, max_speed_x_q};
      ebi_pkg::REG_MAX_SPEED_Y: kept = {1'b0, max_speed_y_q};
      default:                  kept = {16'h0, zero_band_q};
    endcase
    check_register(idx, kept);
  endtask

  task automatic configure_body(input logic [31:0] inv, input logic [31:0] fric,
                                input logic [31:0] mx, input logic [31:0] my,
                                input logic [31:0] band);
    wait_idle();
    set_register(ebi_pkg::REG_INV_MASS, inv);
    set_register(ebi_pkg::REG_FRICTION, fric);
    set_register(ebi_pkg::REG_MAX_SPEED_X, mx);
    set_register(ebi_pkg::REG_MAX_SPEED_Y, my);
    set_register(ebi_pkg::REG_ZERO_BAND, band);
  endtask

  // ---------------------------------------------------------------- random stimulus

  function automatic logic [31:0] rand_value();
    int r;
    logic [31:0] v;
    r = $urandom_range(0, 99);
    if (r < 45) begin
      v = $urandom_range(0, 32'h00FF_FFFF);
      if ($urandom_range(0, 1)) v = -v;
    end else if (r < 75) begin
      v = $urandom;
    end else if (r < 90) begin
      v = $urandom_range(0, 32'h0000_FFFF);
      if ($urandom_range(0, 1)) v = -v;
    end else begin
      case ($urandom_range(0, 3))
        0:       v = 32'h7FFF_FFFF;
        1:       v = 32'h8000_0000;
        2:       v = 32'h0000_0000;
        default: v = 32'hFFFF_FFFF;
      endcase
    end
    return v;
  endfunction

  function automatic logic [15:0] rand_dt();
    if ($urandom_range(0, 99) < 65) return 16'($urandom_range(256, 4369));
    return 16'($urandom_range(0, 65535));
  endfunction

  // frames of a few forces closed by a tick, with position loads and noise mixed in
  task automatic run_random_motion(input int n_items);
    int sent;
    int r;
    int n_force;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 99) < 4) no_idle = !no_idle;
      r = $urandom_range(0, 99);
      if (r < 80) begin
        n_force = $urandom_range(0, 3);
        repeat (n_force)
          send_cmd(ebi_pkg::CMD_FORCE, rand_value(), rand_value(), 16'($urandom));
        send_cmd(ebi_pkg::CMD_TICK, $urandom, $urandom, rand_dt());
        sent += n_force + 1;
      end else if (r < 90) begin
        send_cmd(ebi_pkg::CMD_SETPOS, rand_value(), rand_value(), 16'($urandom));
        sent++;
      end else if (r < 95) begin
        send_cmd(CMD_UNUSED, $urandom, $urandom, 16'($urandom));
        sent++;
      end else begin
        send_cmd(2'($urandom_range(0, 3)), $urandom, $urandom, 16'($urandom));
        sent++;
      end
    end
    no_idle = 1'b0;
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_register_defaults();
    check_register(ebi_pkg::REG_INV_MASS, ebi_pkg::INV_MASS_RST);
    check_register(ebi_pkg::REG_FRICTION, ebi_pkg::FRICTION_RST);
    check_register(ebi_pkg::REG_MAX_SPEED_X, {1'b0, ebi_pkg::MAX_SPEED_X_RST});
    check_register(ebi_pkg::REG_MAX_SPEED_Y, {1'b0, ebi_pkg::MAX_SPEED_Y_RST});
    check_register(ebi_pkg::REG_ZERO_BAND, {16'h0, ebi_pkg::ZERO_BAND_RST});
  endtask

  task automatic test_directed_motion();
    send_cmd(CMD_UNUSED, 32'h1234_5678, 32'h9ABC_DEF0, 16'hFFFF);
    // zero velocity: drag adds nothing
    send_cmd(ebi_pkg::CMD_TICK, 32'h0, 32'h0, 16'hFFFF);
    send_cmd(ebi_pkg::CMD_FORCE, 32'h0064_0000, 32'hFFCE_0000, 16'h0);
    send_cmd(ebi_pkg::CMD_TICK, 32'h0, 32'h0, 16'hFFFF);
    send_cmd(ebi_pkg::CMD_TICK, 32'h0, 32'h0, 16'h0000);
    send_cmd(ebi_pkg::CMD_SETPOS, 32'h7FFF_FFFF, 32'h8000_0000, 16'h0);
    send_cmd(ebi_pkg::CMD_SETPOS, 32'h0, 32'h0, 16'hFFFF);
    send_cmd(CMD_UNUSED, 32'hFFFF_FFFF, 32'h0, 16'h0);
  endtask

  task automatic test_saturation_limits();
    send_cmd(ebi_pkg::CMD_SETPOS, 32'h7FFF_0000, 32'h8000_FFFF, 16'h0);
    // acceleration accumulator overflow in both directions
    send_cmd(ebi_pkg::CMD_FORCE, 32'h7FFF_FFFF, 32'h8000_0000, 16'h0);
    send_cmd(ebi_pkg::CMD_FORCE, 32'h7FFF_FFFF, 32'h8000_0000, 16'h0);
    // speed clamp and position saturation
    send_cmd(ebi_pkg::CMD_TICK, 32'h0, 32'h0, 16'hFFFF);
    send_cmd(ebi_pkg::CMD_FORCE, 32'h8000_0000, 32'h7FFF_FFFF, 16'h0);
    send_cmd(ebi_pkg::CMD_FORCE, 32'h8000_0000, 32'h7FFF_FFFF, 16'h0);
    send_cmd(ebi_pkg::CMD_TICK, 32'h0, 32'h0, 16'hFFFF);
    send_cmd(ebi_pkg::CMD_TICK, 32'h0, 32'h0, 16'h0001);
  endtask

  task automatic test_zero_band_snap();
    send_cmd(ebi_pkg::CMD_SETPOS, 32'h0, 32'h0, 16'h0);
    // band of zero: no speed is snapped to zero
    send_cmd(ebi_pkg::CMD_FORCE, 32'h0001_0000, 32'hFFFF_0000, 16'h0);
    send_cmd(ebi_pkg::CMD_TICK, 32'h0, 32'h0, 16'h0001);
    configure_body(ebi_pkg::INV_MASS_RST, ebi_pkg::FRICTION_RST,
                   32'(ebi_pkg::MAX_SPEED_X_RST), 32'(ebi_pkg::MAX_SPEED_Y_RST),
                   32'h0000_FFFF);
    send_cmd(ebi_pkg::CMD_FORCE, 32'h0000_8000, 32'hFFFF_8000, 16'h0);
    send_cmd(ebi_pkg::CMD_TICK, 32'h0, 32'h0, 16'h1000);
    send_cmd(ebi_pkg::CMD_FORCE, 32'h0020_0000, 32'hFFE0_0000, 16'h0);
    send_cmd(ebi_pkg::CMD_TICK, 32'h0, 32'h0, 16'h1000);
  endtask

  task automatic test_default_random();
    configure_body(ebi_pkg::INV_MASS_RST, ebi_pkg::FRICTION_RST,
                   32'(ebi_pkg::MAX_SPEED_X_RST), 32'(ebi_pkg::MAX_SPEED_Y_RST),
                   32'(ebi_pkg::ZERO_BAND_RST));
    run_random_motion(150);
  endtask

  task automatic test_moderate_config();
    configure_body($urandom_range(32'h1000, 32'h4_0000), $urandom_range(0, 32'h4_0000),
                   $urandom_range(32'h1_0000, 32'h400_0000),
                   $urandom_range(32'h1_0000, 32'h400_0000), $urandom_range(0, 32'h2000));
    run_random_motion(150);
  endtask

  task automatic test_upper_extremes();
    configure_body(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                   32'h0000_FFFF);
    run_random_motion(120);
  endtask

  task automatic test_lower_extremes();
    configure_body(32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
    run_random_motion(100);
  endtask

  task automatic test_random_config();
    configure_body($urandom, $urandom, $urandom, $urandom, $urandom);
    run_random_motion(75);
    configure_body($urandom, $urandom_range(0, 32'h2_0000), $urandom, $urandom, $urandom);
    run_random_motion(75);
  endtask

  task automatic test_back_to_defaults();
    configure_body(ebi_pkg::INV_MASS_RST, ebi_pkg::FRICTION_RST,
                   32'(ebi_pkg::MAX_SPEED_X_RST), 32'(ebi_pkg::MAX_SPEED_Y_RST),
                   32'(ebi_pkg::ZERO_BAND_RST));
    run_random_motion(80);
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_register_defaults();
    test_directed_motion();
    test_saturation_limits();
    test_zero_band_snap();
    test_default_random();
    test_moderate_config();
    test_upper_extremes();
    test_lower_extremes();
    test_random_config();
    test_back_to_defaults();

    wait_idle();
    repeat (20) @(posedge clk);
    $display("covered %0d force, %0d tick, %0d set-position and %0d unused-command transfers",
             cmd_count[ebi_pkg::CMD_FORCE], cmd_count[ebi_pkg::CMD_TICK],
             cmd_count[ebi_pkg::CMD_SETPOS], cmd_count[CMD_UNUSED]);
    $display("%0d results compared, %0d register writes over default and extreme settings",
             results_seen, config_writes);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("timeout with %0d results still outstanding", pending_motion.size());
    $display("DONE: errors detected");
    $finish;
  end

endmodule
